@@ rtl/lpmd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the length-prefixed message deframer.
// Used by the parser, the result queue and the top level; depends on nothing.

package lpmd_pkg;

   typedef enum logic [2:0] {
      PH_LEN,
      PH_EXLEN,
      PH_ID,
      PH_DATA,
      PH_CODE,
      PH_CTRL
   } phase_type;

   typedef enum logic [2:0] {
      EV_HEADER,
      EV_DATA,
      EV_END,
      EV_CODE,
      EV_CBYTE,
      EV_ERROR
   } kind_type;

   localparam logic [15:0] EXT_LEN_MARK = 16'hFFFF;
   localparam logic [3:0]  LEN_LAST_BYTE = 4'd1;
   localparam logic [3:0]  ID_LAST_BYTE = 4'd1;
   localparam logic [3:0]  EXLEN_LAST_BYTE = 4'd7;
   localparam logic [3:0]  CODE_LAST_BYTE = 4'd3;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_PAD_W = 5;

   typedef logic [RSP_PTR_W-1:0] rsp_ptr_type;
   typedef logic [RSP_PTR_W:0]   rsp_count_type;

   typedef struct packed {
      logic               last;
      logic signed [31:0] control_code;
      logic [7:0]         payload_byte;
      logic [63:0]        byte_offset;
      logic [63:0]        payload_length;
      logic [15:0]        message_id;
      kind_type           event_kind;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } step_type;

endpackage

@@ rtl/lpmd_parser.sv @@
`timescale 1ns / 1ps
// Frame parser: holds the framing state and works out, for one stream byte,
// the next state and up to two result items. Depends on lpmd_pkg.

module lpmd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [7:0]         byte_in,
   output lpmd_pkg::step_type step
);

   lpmd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  fbc_ff, fbc_in;
   logic [63:0] len_ff, len_in;
   logic [15:0] id_ff, id_in;
   logic [63:0] off_ff, off_in;
   logic [31:0] code_ff, code_in;

   logic [63:0] off_inc;
   logic [31:0] code_shift;
   logic [15:0] len_short;
   logic [3:0]  fbc_len;
   logic        reached;
   logic [1:0]  cnt;
   lpmd_pkg::kind_type kind0, kind1;
   logic [63:0] off0, off1;
   logic [7:0]  byte0;
   logic [31:0] code0;
   logic        last0, last1;

   // An unused phase code restarts the length field from its first byte.
   always_comb begin
      off_inc    = off_ff + 64'd1;
      code_shift = {code_ff[23:0], byte_in};
      fbc_len    = (phase_ff == lpmd_pkg::PH_LEN) ? fbc_ff : 4'd0;
      len_short  = {len_ff[7:0], byte_in};
      reached    = (off_inc >= len_ff);
   end

   always_comb begin
      phase_in = phase_ff;
      fbc_in   = fbc_ff;
      len_in   = len_ff;
      id_in    = id_ff;
      off_in   = off_ff;
      code_in  = code_ff;
      unique case (phase_ff)
         lpmd_pkg::PH_EXLEN: begin
            len_in = {len_ff[55:0], byte_in};
            fbc_in = fbc_ff + 4'd1;
            if (fbc_ff >= lpmd_pkg::EXLEN_LAST_BYTE) begin
               fbc_in   = '0;
               phase_in = lpmd_pkg::PH_ID;
            end
         end
         lpmd_pkg::PH_ID: begin
            id_in  = {id_ff[7:0], byte_in};
            fbc_in = fbc_ff + 4'd1;
            if (fbc_ff >= lpmd_pkg::ID_LAST_BYTE) begin
               fbc_in  = '0;
               off_in  = '0;
               code_in = '0;
               if (id_in != 16'd0) begin
                  phase_in = (len_ff == 64'd0) ? lpmd_pkg::PH_LEN : lpmd_pkg::PH_DATA;
               end else begin
                  phase_in = (len_ff == 64'd0) ? lpmd_pkg::PH_LEN : lpmd_pkg::PH_CODE;
               end
            end
         end
         lpmd_pkg::PH_DATA: begin
            off_in = off_inc;
            if (reached) begin
               phase_in = lpmd_pkg::PH_LEN;
            end
         end
         lpmd_pkg::PH_CODE: begin
            code_in = code_shift;
            fbc_in  = fbc_ff + 4'd1;
            off_in  = off_inc;
            if (fbc_ff >= lpmd_pkg::CODE_LAST_BYTE) begin
               fbc_in   = '0;
               phase_in = reached ? lpmd_pkg::PH_LEN : lpmd_pkg::PH_CTRL;
            end else if (reached) begin
               fbc_in   = '0;
               phase_in = lpmd_pkg::PH_LEN;
            end
         end
         lpmd_pkg::PH_CTRL: begin
            off_in = off_inc;
            if (reached) begin
               phase_in = lpmd_pkg::PH_LEN;
            end
         end
         default: begin
            phase_in = lpmd_pkg::PH_LEN;
            if (fbc_len == 4'd0) begin
               id_in  = '0;
               off_in = '0;
               len_in = {56'd0, byte_in};
            end else begin
               len_in = {48'd0, len_short};
            end
            fbc_in = fbc_len + 4'd1;
            if (fbc_len >= lpmd_pkg::LEN_LAST_BYTE) begin
               fbc_in = '0;
               if (len_short == lpmd_pkg::EXT_LEN_MARK) begin
                  len_in   = '0;
                  phase_in = lpmd_pkg::PH_EXLEN;
               end else begin
                  phase_in = lpmd_pkg::PH_ID;
               end
            end
         end
      endcase
   end

   always_comb begin
      cnt   = 2'd0;
      kind0 = lpmd_pkg::EV_HEADER;
      kind1 = lpmd_pkg::EV_END;
      off0  = '0;
      off1  = '0;
      byte0 = '0;
      code0 = '0;
      last0 = 1'b0;
      last1 = 1'b0;
      unique case (phase_ff)
         lpmd_pkg::PH_ID: begin
            if (fbc_ff >= lpmd_pkg::ID_LAST_BYTE) begin
               if (id_in != 16'd0) begin
                  cnt   = (len_ff == 64'd0) ? 2'd2 : 2'd1;
                  kind0 = lpmd_pkg::EV_HEADER;
                  last1 = 1'b1;
               end else if (len_ff == 64'd0) begin
                  cnt   = 2'd1;
                  kind0 = lpmd_pkg::EV_ERROR;
                  last0 = 1'b1;
               end
            end
         end
         lpmd_pkg::PH_DATA: begin
            cnt   = reached ? 2'd2 : 2'd1;
            kind0 = lpmd_pkg::EV_DATA;
            off0  = off_ff;
            byte0 = byte_in;
            off1  = off_inc;
            last1 = 1'b1;
         end
         lpmd_pkg::PH_CODE: begin
            if (fbc_ff >= lpmd_pkg::CODE_LAST_BYTE) begin
               cnt   = 2'd1;
               kind0 = lpmd_pkg::EV_CODE;
               code0 = code_shift;
               last0 = reached;
            end else if (reached) begin
               cnt   = 2'd1;
               kind0 = lpmd_pkg::EV_ERROR;
               off0  = off_inc;
               last0 = 1'b1;
            end
         end
         lpmd_pkg::PH_CTRL: begin
            cnt   = 2'd1;
            kind0 = lpmd_pkg::EV_CBYTE;
            off0  = off_ff;
            byte0 = byte_in;
            last0 = reached;
         end
         default: begin
            cnt = 2'd0;
         end
      endcase
   end

   always_comb begin
      step.count                 = cnt;
      step.first.event_kind      = kind0;
      step.first.message_id      = id_in;
      step.first.payload_length  = len_in;
      step.first.byte_offset     = off0;
      step.first.payload_byte    = byte0;
      step.first.control_code    = code0;
      step.first.last            = last0;
      step.second.event_kind     = kind1;
      step.second.message_id     = id_in;
      step.second.payload_length = len_in;
      step.second.byte_offset    = off1;
      step.second.payload_byte   = '0;
      step.second.control_code   = '0;
      step.second.last           = last1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lpmd_pkg::PH_LEN;
         fbc_ff   <= '0;
         len_ff   <= '0;
         id_ff    <= '0;
         off_ff   <= '0;
         code_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         fbc_ff   <= fbc_in;
         len_ff   <= len_in;
         id_ff    <= id_in;
         off_ff   <= off_in;
         code_ff  <= code_in;
      end
   end

   a_fbc_range: assert property (@(posedge clock) disable iff (reset)
      fbc_ff <= lpmd_pkg::EXLEN_LAST_BYTE)
      else $error("Field byte count is out of range.");

   a_short_fields: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lpmd_pkg::PH_LEN || phase_ff == lpmd_pkg::PH_ID) |->
      fbc_ff <= lpmd_pkg::LEN_LAST_BYTE)
      else $error("Length or id field count exceeds two bytes.");

   a_code_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lpmd_pkg::PH_CODE) |-> fbc_ff <= lpmd_pkg::CODE_LAST_BYTE)
      else $error("Control code count exceeds four bytes.");

   a_payload_open: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lpmd_pkg::PH_DATA || phase_ff == lpmd_pkg::PH_CTRL) |->
      off_ff < len_ff)
      else $error("Payload phase entered with no bytes left.");

endmodule

@@ rtl/lpmd_rsp_fifo.sv @@
`timescale 1ns / 1ps
// Result queue: takes up to two result items per cycle from the parser and
// hands them out one per cycle while the result channel is ready. Depends on lpmd_pkg.

module lpmd_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lpmd_pkg::step_type step,
   output logic               room,
   output logic               out_valid,
   input  logic               out_ready,
   output lpmd_pkg::rsp_type  out_item
);

   lpmd_pkg::rsp_type       mem_ff [lpmd_pkg::RSP_DEPTH];
   lpmd_pkg::rsp_ptr_type   wr_ptr_ff, wr_ptr_in;
   lpmd_pkg::rsp_ptr_type   rd_ptr_ff, rd_ptr_in;
   lpmd_pkg::rsp_count_type count_ff, count_in;
   lpmd_pkg::rsp_ptr_type   wr_next;
   logic [1:0]              push_cnt;
   logic                    pop;

   always_comb begin
      push_cnt  = push ? step.count : 2'd0;
      out_valid = (count_ff != '0);
      pop       = out_valid && out_ready;
      room      = (count_ff <= lpmd_pkg::rsp_count_type'(lpmd_pkg::RSP_DEPTH - 2));
      wr_next   = lpmd_pkg::rsp_ptr_type'(wr_ptr_ff + 1'b1);
      wr_ptr_in = lpmd_pkg::rsp_ptr_type'(wr_ptr_ff + push_cnt);
      rd_ptr_in = lpmd_pkg::rsp_ptr_type'(rd_ptr_ff + pop);
      count_in  = lpmd_pkg::rsp_count_type'(count_ff + push_cnt - pop);
      out_item  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= step.first;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_next] <= step.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lpmd_pkg::rsp_count_type'(lpmd_pkg::RSP_DEPTH))
      else $error("Result queue holds more items than it has entries.");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> room)
      else $error("Result items pushed without room.");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      lpmd_pkg::rsp_ptr_type'(wr_ptr_ff - rd_ptr_ff) ==
      lpmd_pkg::rsp_ptr_type'(count_ff))
      else $error("Queue pointers disagree with the fill count.");

endmodule

@@ rtl/length_prefixed_message_deframer_top.sv @@
`timescale 1ns / 1ps
// Length-prefixed message deframer, top level: input register, frame parser
// and result queue. Depends on lpmd_pkg, lpmd_parser and lpmd_rsp_fifo.
//
// The block takes one stream byte per clock while the result queue has room
// and reports data headers, data bytes with their offsets, end markers,
// control codes, control bytes and errors. An accepted byte waits in the
// input register, is parsed straight out of it once the result queue has
// room, and its result items are registered in the queue before output.
// Most bytes give at most one result item; the second id byte of an empty
// data frame and the byte that completes a data payload give two, and the
// result queue (four entries, one item out per cycle while rsp_tready is
// high) must hand out both; a long run of such bytes is throttled to match.
// The output side alone sets the sustained rate: with rsp_tready held high,
// data bytes flow at one per clock. No clearing pass follows reset.

module length_prefixed_message_deframer_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // [7:0] stream_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [2:0] event_kind, [18:3] message_id, [82:19] payload_length,
   // [146:83] byte_offset, [154:147] payload_byte, [186:155] control_code,
   // [191:187] zero
   output logic [191:0] rsp_tdata,
   output logic         rsp_tlast
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff, in_byte_in;
   logic               room;
   logic               advance;
   lpmd_pkg::step_type step;
   lpmd_pkg::rsp_type  out_item;

   always_comb begin
      advance     = in_valid_ff && room;
      req_tready  = !in_valid_ff || room;
      in_byte_in  = in_byte_ff;
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_byte_in  = req_tdata;
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   lpmd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .byte_in (in_byte_ff),
      .step    (step)
   );

   lpmd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .step      (step),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {{lpmd_pkg::RSP_PAD_W{1'b0}}, out_item.control_code,
                       out_item.payload_byte, out_item.byte_offset,
                       out_item.payload_length, out_item.message_id,
                       out_item.event_kind};
   assign rsp_tlast = out_item.last;

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !room) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("Held input item was lost or changed.");

   a_header_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_item.event_kind == lpmd_pkg::EV_HEADER) |-> !rsp_tlast)
      else $error("A data header was marked as the last item of a frame.");

   a_data_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_item.event_kind == lpmd_pkg::EV_DATA) |-> !rsp_tlast)
      else $error("A data byte was marked as the last item of a frame.");

endmodule

@@ bench/length_prefixed_message_deframer_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for length_prefixed_message_deframer_top: sends framed byte
// streams, predicts every event item and checks each one as it comes out.
// Depends on lpmd_pkg for the phase and event kind types.

module length_prefixed_message_deframer_top_tb;

   typedef struct {
      lpmd_pkg::kind_type kind;
      logic [15:0]        id;
      logic [63:0]        length;
      logic [63:0]        offset;
      logic [7:0]         value;
      logic signed [31:0] code;
      logic               last;
   } frame_event_type;

   class deframer_scoreboard;
      lpmd_pkg::phase_type phase = lpmd_pkg::PH_LEN;
      int              field_count = 0;
      logic [63:0]     length_acc = '0;
      logic [15:0]     current_id = '0;
      logic [63:0]     offset_acc = '0;
      logic [31:0]     code_acc = '0;
      frame_event_type pending_events[$];
      int              failures = 0;

      function void push_event(lpmd_pkg::kind_type kind, logic [63:0] offset,
                               logic [7:0] value, logic [31:0] code, logic last);
         frame_event_type ev;
         ev.kind = kind;
         ev.id = current_id;
         ev.length = length_acc;
         ev.offset = offset;
         ev.value = value;
         ev.code = code;
         ev.last = last;
         pending_events.push_back(ev);
      endfunction

      function void note_byte(logic [7:0] b);
         logic [63:0] prev;
         logic        fin;
         case (phase)
            lpmd_pkg::PH_EXLEN: begin
               length_acc = {length_acc[55:0], b};
               field_count++;
               if (field_count >= 8) begin
                  field_count = 0;
                  phase = lpmd_pkg::PH_ID;
               end
            end
            lpmd_pkg::PH_ID: begin
               current_id = {current_id[7:0], b};
               field_count++;
               if (field_count >= 2) begin
                  field_count = 0;
                  offset_acc = '0;
                  code_acc = '0;
                  if (current_id != 0) begin
                     push_event(lpmd_pkg::EV_HEADER, 0, 0, 0, 1'b0);
                     if (length_acc == 0) begin
                        push_event(lpmd_pkg::EV_END, 0, 0, 0, 1'b1);
                        phase = lpmd_pkg::PH_LEN;
                     end else begin
                        phase = lpmd_pkg::PH_DATA;
                     end
                  end else if (length_acc == 0) begin
                     push_event(lpmd_pkg::EV_ERROR, 0, 0, 0, 1'b1);
                     phase = lpmd_pkg::PH_LEN;
                  end else begin
                     phase = lpmd_pkg::PH_CODE;
                  end
               end
            end
            lpmd_pkg::PH_DATA: begin
               prev = offset_acc;
               offset_acc = prev + 1;
               push_event(lpmd_pkg::EV_DATA, prev, b, 0, 1'b0);
               if (offset_acc >= length_acc) begin
                  push_event(lpmd_pkg::EV_END, offset_acc, 0, 0, 1'b1);
                  phase = lpmd_pkg::PH_LEN;
               end
            end
            lpmd_pkg::PH_CODE: begin
               code_acc = {code_acc[23:0], b};
               field_count++;
               offset_acc = offset_acc + 1;
               if (field_count >= 4) begin
                  fin = (offset_acc >= length_acc);
                  field_count = 0;
                  push_event(lpmd_pkg::EV_CODE, 0, 0, code_acc, fin);
                  phase = fin ? lpmd_pkg::PH_LEN : lpmd_pkg::PH_CTRL;
               end else if (offset_acc >= length_acc) begin
                  field_count = 0;
                  push_event(lpmd_pkg::EV_ERROR, offset_acc, 0, 0, 1'b1);
                  phase = lpmd_pkg::PH_LEN;
               end
            end
            lpmd_pkg::PH_CTRL: begin
               prev = offset_acc;
               offset_acc = prev + 1;
               fin = (offset_acc >= length_acc);
               push_event(lpmd_pkg::EV_CBYTE, prev, b, 0, fin);
               if (fin) begin
                  phase = lpmd_pkg::PH_LEN;
               end
            end
            default: begin
               if (phase != lpmd_pkg::PH_LEN) begin
                  phase = lpmd_pkg::PH_LEN;
                  field_count = 0;
               end
               if (field_count == 0) begin
                  length_acc = '0;
                  current_id = '0;
                  offset_acc = '0;
               end
               length_acc = {48'd0, length_acc[7:0], b};
               field_count++;
               if (field_count >= 2) begin
                  field_count = 0;
                  if (length_acc == 64'h0000_0000_0000_FFFF) begin
                     length_acc = '0;
                     phase = lpmd_pkg::PH_EXLEN;
                  end else begin
                     phase = lpmd_pkg::PH_ID;
                  end
               end
            end
         endcase
      endfunction

      function void compare(string name, logic [63:0] expected, logic [63:0] actual);
         if (expected !== actual) begin
            $error("%s mismatch: expected %0h actual %0h", name, expected, actual);
            failures++;
         end
      endfunction

      function void check_item(logic [191:0] data, logic last);
         frame_event_type ev;
         if (pending_events.size() == 0) begin
            $error("unexpected result item %0h", data);
            failures++;
            return;
         end
         ev = pending_events.pop_front();
         compare("event_kind", ev.kind, data[2:0]);
         compare("message_id", ev.id, data[18:3]);
         compare("payload_length", ev.length, data[82:19]);
         compare("byte_offset", ev.offset, data[146:83]);
         compare("payload_byte", ev.value, data[154:147]);
         compare("control_code", {32'd0, ev.code}, {32'd0, data[186:155]});
         compare("last", ev.last, last);
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'd0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;
   logic         rsp_tlast;

   deframer_scoreboard sb = new();
   bit calm = 1'b0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int bytes_sent = 0;

   length_prefixed_message_deframer_top u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = 80;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 12);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_item(rsp_tdata, rsp_tlast);
      end
   end

   task automatic send_byte(input logic [7:0] value);
      while (!calm && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(value);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [15:0] id, input logic [63:0] length,
                             input bit extended, input int payload_count);
      if (extended) begin
         send_byte(8'hFF);
         send_byte(8'hFF);
         for (int i = 7; i >= 0; i--) send_byte(length[8*i +: 8]);
      end else begin
         send_byte(length[15:8]);
         send_byte(length[7:0]);
      end
      send_byte(id[15:8]);
      send_byte(id[7:0]);
      for (int i = 0; i < payload_count; i++) send_byte(8'($urandom_range(255)));
   endtask

   task automatic drain_results();
      while (sb.pending_events.size() != 0) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
   endtask

   initial begin
      #2_000_000;
      $display("length_prefixed_message_deframer_top_tb NOT OK");
      $finish;
   end

   initial begin
      int frame_index;
      int pick;
      logic [15:0] id;
      logic [63:0] length;
      bit extended;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_frame(16'hFFFF, 0, 1'b0, 0);
      send_frame(16'h0000, 0, 1'b0, 0);
      send_frame(16'h0001, 1, 1'b0, 0);
      send_byte(8'hFF);
      send_frame(16'h0000, 4, 1'b0, 0);
      send_byte(8'h80);
      repeat (3) send_byte(8'h00);
      send_frame(16'h0000, 5, 1'b0, 0);
      send_byte(8'h7F);
      repeat (3) send_byte(8'hFF);
      send_byte(8'h00);
      send_frame(16'h0000, 2, 1'b0, 2);

      frame_index = 0;
      while (bytes_sent < 1400) begin
         if (frame_index == 15 || frame_index == 70) hold_asks++;
         if (frame_index == 50 || frame_index == 85) drain_results();
         calm = (frame_index >= 30 && frame_index < 45);
         id = ($urandom_range(99) < 40) ? 16'h0000 : 16'($urandom_range(65535, 1));
         pick = $urandom_range(99);
         if (pick < 10) length = 0;
         else if (pick < 75) length = $urandom_range(8, 1);
         else if (pick < 92) length = $urandom_range(24, 9);
         else length = $urandom_range(60, 25);
         extended = ($urandom_range(99) < 15);
         send_frame(id, length, extended, int'(length));
         frame_index++;
      end
      calm = 1'b0;

      length = {$urandom, $urandom};
      length[63] = 1'b1;
      id = $urandom_range(1) ? 16'h0000 : 16'($urandom_range(65535, 1));
      send_frame(id, length, 1'b1, 20);
      req_tvalid <= 1'b0;

      drain_results();
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.pending_events.size() == 0) begin
         $display("length_prefixed_message_deframer_top_tb OK");
      end else begin
         $display("length_prefixed_message_deframer_top_tb NOT OK");
      end
      $finish;
   end

endmodule
